// ===== rtl/kruskal_mst_union_find_macros.svh =====
// Assertion helpers for the spanning tree block.
`ifndef KRUSKAL_MST_UNION_FIND_MACROS_SVH
`define KRUSKAL_MST_UNION_FIND_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KMUF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmuf: same-cycle check failed");
`define KMUF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmuf: next-cycle check failed");
`else
`define KMUF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KMUF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/kmuf_pkg.sv =====
package kmuf_pkg;

    localparam int MAX_NODES_DEF   = 1024;
    localparam int WEIGHT_BITS_DEF = 24;
    localparam int CFG_W           = 11;
    localparam int NODE_IN_W       = 10;
    localparam int WEIGHT_IN_W     = 24;
    localparam int COST_W          = 34;
    localparam int LEFT_W          = 10;

    typedef struct packed {
        logic                   mode;
        logic [NODE_IN_W-1:0]   node_a;
        logic [NODE_IN_W-1:0]   node_b;
        logic [WEIGHT_IN_W-1:0] weight;
    } t_edge;

    typedef struct packed {
        logic              joined;
        logic [COST_W-1:0] total_cost;
        logic [LEFT_W-1:0] merges_left;
        logic              done_res;
    } t_res;

    typedef struct packed {
        logic [CFG_W-1:0] node_count;
    } t_cfg;

    localparam logic MODE_CLEAR = 1'b0;
    localparam logic MODE_EDGE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_FRD,
        S_FWT,
        S_CRD,
        S_CWT,
        S_MRG1,
        S_MRG2,
        S_OUT
    } t_state;

endpackage

// ===== rtl/kmuf_chan.sv =====
interface kmuf_chan #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/kmuf_mem.sv =====
module kmuf_mem #(
    parameter int DEPTH  = 1024,
    parameter int NODE_W = 10,
    parameter int SIZE_W = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [NODE_W-1:0] i_waddr,
    input  logic [NODE_W-1:0] i_wparent,
    input  logic [SIZE_W-1:0] i_wsize,
    input  logic              i_re,
    input  logic [NODE_W-1:0] i_raddr,
    output logic [NODE_W-1:0] o_rparent,
    output logic [SIZE_W-1:0] o_rsize
);

    // one entry per node: parent link and set size
    logic [NODE_W+SIZE_W-1:0] r_mem [DEPTH];
    logic [NODE_W+SIZE_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wparent, i_wsize};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd <= r_mem[i_raddr];
        end
    end

    assign o_rparent = r_rd[NODE_W+SIZE_W-1:SIZE_W];
    assign o_rsize   = r_rd[SIZE_W-1:0];

endmodule

// ===== rtl/kmuf_ctrl.sv =====
`include "kruskal_mst_union_find_macros.svh"
module kmuf_ctrl #(
    parameter int MAX_NODES   = 1024,
    parameter int WEIGHT_BITS = 24,
    parameter int NODE_W      = 10,
    parameter int SIZE_W      = 11,
    parameter int ACT_W       = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [ACT_W-1:0]   i_node_count,
    input  logic               i_edge_valid,
    input  kmuf_pkg::t_edge    i_edge,
    output logic               o_edge_ready,
    input  logic               i_out_free,
    output logic               o_res_load,
    output kmuf_pkg::t_res     o_res,
    output logic               o_mem_we,
    output logic [NODE_W-1:0]  o_mem_waddr,
    output logic [NODE_W-1:0]  o_mem_wparent,
    output logic [SIZE_W-1:0]  o_mem_wsize,
    output logic               o_mem_re,
    output logic [NODE_W-1:0]  o_mem_raddr,
    input  logic [NODE_W-1:0]  i_mem_parent,
    input  logic [SIZE_W-1:0]  i_mem_size
);
    import kmuf_pkg::*;

    localparam logic [ACT_W-1:0] MAX_ACT = ACT_W'(MAX_NODES);

    t_state                 r_state, n_state;
    logic                   r_side, n_side;
    logic [NODE_W-1:0]      r_x, n_x;
    logic [NODE_W-1:0]      r_a_node, n_a_node;
    logic [NODE_W-1:0]      r_b_node, n_b_node;
    logic [NODE_W-1:0]      r_root_a, n_root_a;
    logic [NODE_W-1:0]      r_root_b, n_root_b;
    logic [SIZE_W-1:0]      r_size_a, n_size_a;
    logic [SIZE_W-1:0]      r_size_b, n_size_b;
    logic [WEIGHT_BITS-1:0] r_w, n_w;
    logic [ACT_W-1:0]       r_idx, n_idx;
    logic [ACT_W-1:0]       r_active, n_active;
    logic [ACT_W-1:0]       r_rem, n_rem;
    logic [COST_W-1:0]      r_cost, n_cost;
    logic                   r_fin, n_fin;
    logic                   r_joined, n_joined;
    logic                   r_silent, n_silent;

    logic [ACT_W-1:0]  w_eff;
    logic [ACT_W-1:0]  w_a_wide, w_b_wide;
    logic [NODE_W-1:0] w_cur_root, w_big, w_small;
    logic [SIZE_W-1:0] w_small_size;
    logic              w_swap;

    always_comb begin
        if (i_node_count == '0) begin
            w_eff = ACT_W'(1);
        end else if (i_node_count > MAX_ACT) begin
            w_eff = MAX_ACT;
        end else begin
            w_eff = i_node_count;
        end
    end

    assign w_a_wide     = ACT_W'(i_edge.node_a);
    assign w_b_wide     = ACT_W'(i_edge.node_b);
    assign w_cur_root   = r_side ? r_root_b : r_root_a;
    assign w_swap       = (r_size_a < r_size_b);
    assign w_big        = w_swap ? r_root_b : r_root_a;
    assign w_small      = w_swap ? r_root_a : r_root_b;
    assign w_small_size = w_swap ? r_size_a : r_size_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_idx    <= '0;
            r_active <= MAX_ACT;
            r_rem    <= MAX_ACT - ACT_W'(1);
            r_cost   <= '0;
            r_fin    <= 1'b0;
            r_silent <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_active <= n_active;
            r_rem    <= n_rem;
            r_cost   <= n_cost;
            r_fin    <= n_fin;
            r_silent <= n_silent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side   <= n_side;
        r_x      <= n_x;
        r_a_node <= n_a_node;
        r_b_node <= n_b_node;
        r_root_a <= n_root_a;
        r_root_b <= n_root_b;
        r_size_a <= n_size_a;
        r_size_b <= n_size_b;
        r_w      <= n_w;
        r_joined <= n_joined;
    end

    always_comb begin
        n_state  = r_state;
        n_side   = r_side;
        n_x      = r_x;
        n_a_node = r_a_node;
        n_b_node = r_b_node;
        n_root_a = r_root_a;
        n_root_b = r_root_b;
        n_size_a = r_size_a;
        n_size_b = r_size_b;
        n_w      = r_w;
        n_idx    = r_idx;
        n_active = r_active;
        n_rem    = r_rem;
        n_cost   = r_cost;
        n_fin    = r_fin;
        n_joined = r_joined;
        n_silent = r_silent;

        o_edge_ready  = 1'b0;
        o_res_load    = 1'b0;
        o_mem_we      = 1'b0;
        o_mem_waddr   = r_x;
        o_mem_wparent = w_cur_root;
        o_mem_wsize   = i_mem_size;
        o_mem_re      = 1'b0;
        o_mem_raddr   = r_x;

        case (r_state)
            S_IDLE: begin
                o_edge_ready = 1'b1;
                if (i_edge_valid) begin
                    if (i_edge.mode == MODE_CLEAR) begin
                        n_active = w_eff;
                        n_idx    = '0;
                        n_silent = 1'b0;
                        n_state  = S_CLR;
                    end else if (r_fin || (w_a_wide >= r_active) ||
                                 (w_b_wide >= r_active)) begin
                        n_joined = 1'b0;
                        n_state  = S_OUT;
                    end else begin
                        n_x      = NODE_W'(w_a_wide);
                        n_a_node = NODE_W'(w_a_wide);
                        n_b_node = NODE_W'(w_b_wide);
                        n_w      = WEIGHT_BITS'(COST_W'(i_edge.weight));
                        n_side   = 1'b0;
                        n_state  = S_FRD;
                    end
                end
            end
            S_CLR: begin
                // restore one node per cycle to a one-node set
                o_mem_we      = 1'b1;
                o_mem_waddr   = NODE_W'(r_idx);
                o_mem_wparent = NODE_W'(r_idx);
                o_mem_wsize   = SIZE_W'(1);
                if (r_idx == r_active - ACT_W'(1)) begin
                    n_rem    = r_active - ACT_W'(1);
                    n_cost   = '0;
                    n_fin    = (r_active == ACT_W'(1));
                    n_joined = 1'b0;
                    n_state  = r_silent ? S_IDLE : S_OUT;
                end else begin
                    n_idx = r_idx + ACT_W'(1);
                end
            end
            S_FRD: begin
                o_mem_re = 1'b1;
                n_state  = S_FWT;
            end
            S_FWT: begin
                if (i_mem_parent == r_x) begin
                    if (r_side) begin
                        n_root_b = r_x;
                        n_size_b = i_mem_size;
                        n_x      = r_b_node;
                    end else begin
                        n_root_a = r_x;
                        n_size_a = i_mem_size;
                        n_x      = r_a_node;
                    end
                    n_state = S_CRD;
                end else begin
                    n_x     = i_mem_parent;
                    n_state = S_FRD;
                end
            end
            S_CRD: begin
                if (r_x == w_cur_root) begin
                    if (r_side) begin
                        n_state = S_MRG1;
                    end else begin
                        n_side  = 1'b1;
                        n_x     = r_b_node;
                        n_state = S_FRD;
                    end
                end else begin
                    o_mem_re = 1'b1;
                    n_state  = S_CWT;
                end
            end
            S_CWT: begin
                // point this node straight at its root, then follow the old link
                o_mem_we = 1'b1;
                n_x      = i_mem_parent;
                n_state  = S_CRD;
            end
            S_MRG1: begin
                if (r_root_a == r_root_b) begin
                    n_joined = 1'b0;
                    n_state  = S_OUT;
                end else begin
                    o_mem_we      = 1'b1;
                    o_mem_waddr   = w_big;
                    o_mem_wparent = w_big;
                    o_mem_wsize   = r_size_a + r_size_b;
                    n_state       = S_MRG2;
                end
            end
            S_MRG2: begin
                o_mem_we      = 1'b1;
                o_mem_waddr   = w_small;
                o_mem_wparent = w_big;
                o_mem_wsize   = w_small_size;
                n_cost        = r_cost + COST_W'(r_w);
                if (r_rem != '0) begin
                    n_rem = r_rem - ACT_W'(1);
                end
                n_fin    = (n_rem == '0);
                n_joined = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.joined      = r_joined;
    assign o_res.total_cost  = r_cost;
    assign o_res.merges_left = LEFT_W'(r_rem);
    assign o_res.done_res    = r_fin;

    `KMUF_ASSERT_SAME(a_fin_means_no_merges, i_clk, i_rst_n, r_fin, r_rem == '0)
    `KMUF_ASSERT_SAME(a_sweep_in_range, i_clk, i_rst_n, r_state == S_CLR, r_idx < r_active)
    `KMUF_ASSERT_SAME(a_write_states, i_clk, i_rst_n, o_mem_we, (r_state == S_CLR || r_state == S_CWT || r_state == S_MRG1 || r_state == S_MRG2))
    `KMUF_ASSERT_NEXT(a_merge_counts_down, i_clk, i_rst_n, (r_state == S_MRG2 && r_rem != '0), r_rem == ACT_W'($past(r_rem) - ACT_W'(1)))

endmodule

// ===== rtl/kruskal_mst_union_find.sv =====
// Kruskal spanning tree accumulator. Feed edges in nondecreasing weight order
// (not checked) on i_edge; each item gives exactly one result on o_res. An item
// with mode 0 clears the union-find table to node_count one-node sets and starts
// a run; an item with mode 1 offers an edge, which joins two sets when its
// endpoint roots differ and then adds its weight to total_cost. Edges with an
// endpoint at or above the node count in use, or offered after the tree is
// complete, are ignored. node_count (0 reads as 1, above MAX_NODES as MAX_NODES)
// is taken at the next clear item. The table sits in one synchronous memory,
// and every parent-table read is registered (address, then data). An edge
// walks parent links from each endpoint up to its root, then points every node
// on that path straight at the root (path compression); when the two roots
// differ it writes the merged root and size, then links the smaller root under
// it. A clear item writes one table entry per cycle for each node in use.
// After reset the block sweeps all MAX_NODES entries before it takes its first
// item; configuration writes are taken at any time. One item is worked on at a
// time; the next is taken while the previous result still waits on o_res.
module kruskal_mst_union_find #(
    parameter int MAX_NODES   = kmuf_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = kmuf_pkg::WEIGHT_BITS_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    kmuf_chan.sink   i_edge,
    kmuf_chan.sink   i_cfg,
    kmuf_chan.source o_res
);
    import kmuf_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int SIZE_W = $clog2(MAX_NODES + 1);
    localparam int ACT_W  = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;

    logic [ACT_W-1:0]  r_node_count;
    logic              r_out_valid;
    t_res              r_out;

    logic              w_out_free;
    logic              w_res_load;
    t_res              w_res;
    logic              w_edge_ready;
    logic              w_we, w_re;
    logic [NODE_W-1:0] w_waddr, w_wparent, w_raddr, w_rparent;
    logic [SIZE_W-1:0] w_wsize, w_rsize;

    // configuration: always ready, store the value for the next clear item
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= ACT_W'(MAX_NODES);
        end else if (i_cfg.valid) begin
            r_node_count <= ACT_W'(i_cfg.data.node_count);
        end
    end

    // output register: free when empty or when the held transaction leaves now
    assign w_out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;
    assign i_edge.ready = w_edge_ready;

    kmuf_ctrl #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .NODE_W      (NODE_W),
        .SIZE_W      (SIZE_W),
        .ACT_W       (ACT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_node_count  (r_node_count),
        .i_edge_valid  (i_edge.valid),
        .i_edge        (i_edge.data),
        .o_edge_ready  (w_edge_ready),
        .i_out_free    (w_out_free),
        .o_res_load    (w_res_load),
        .o_res         (w_res),
        .o_mem_we      (w_we),
        .o_mem_waddr   (w_waddr),
        .o_mem_wparent (w_wparent),
        .o_mem_wsize   (w_wsize),
        .o_mem_re      (w_re),
        .o_mem_raddr   (w_raddr),
        .i_mem_parent  (w_rparent),
        .i_mem_size    (w_rsize)
    );

    kmuf_mem #(
        .DEPTH  (MAX_NODES),
        .NODE_W (NODE_W),
        .SIZE_W (SIZE_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wparent (w_wparent),
        .i_wsize   (w_wsize),
        .i_re      (w_re),
        .i_raddr   (w_raddr),
        .o_rparent (w_rparent),
        .o_rsize   (w_rsize)
    );

endmodule
